FILE: rtl/core/ubsp_pkg.sv
`default_nettype none
package ubsp_pkg;
  localparam int MAX_POINTS_D = 64;
  localparam int MAX_ORDER_D = 8;
  localparam int COORD_FRAC_BITS_D = 16;
  localparam int U_FRAC_BITS_D = 16;
  localparam int RECIP_BITS = 20;
  localparam int COORD_W = 32;
  localparam int U_W = 23;
  localparam int ORDER_W = 4;
  localparam int COUNT_W = 7;
  localparam int CFG_W = 7;

  localparam logic [0:0] CFG_ORDER = 1'b0;
  localparam logic [0:0] CFG_COUNT = 1'b1;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_URANGE = 2'd1;
  localparam logic [1:0] ST_BADCFG = 2'd2;

  // reciprocal ROM: floor((2^RECIP_BITS + floor(d/2)) / d), 20 fraction bits
  function automatic logic [RECIP_BITS:0] recip_rom(input logic [ORDER_W:0] d);
    logic [RECIP_BITS:0] r;
    unique case (d)
      5'd1:    r = (RECIP_BITS+1)'(1048576);
      5'd2:    r = (RECIP_BITS+1)'(524288);
      5'd3:    r = (RECIP_BITS+1)'(349525);
      5'd4:    r = (RECIP_BITS+1)'(262144);
      5'd5:    r = (RECIP_BITS+1)'(209715);
      5'd6:    r = (RECIP_BITS+1)'(174763);
      5'd7:    r = (RECIP_BITS+1)'(149797);
      5'd8:    r = (RECIP_BITS+1)'(131072);
      5'd9:    r = (RECIP_BITS+1)'(116508);
      5'd10:   r = (RECIP_BITS+1)'(104858);
      5'd11:   r = (RECIP_BITS+1)'(95325);
      5'd12:   r = (RECIP_BITS+1)'(87381);
      5'd13:   r = (RECIP_BITS+1)'(80660);
      5'd14:   r = (RECIP_BITS+1)'(74898);
      5'd15:   r = (RECIP_BITS+1)'(69905);
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/uniform_bspline_point_eval.sv
`default_nettype none
// channel | handshake           | payload
// in      | in_valid/in_stall   | in_cmd, in_point_index, in_coord_x/y/z, in_param_u
// out     | out_valid/out_stall | out_point_x/y/z, out_status
// cfg     | cfg_we              | cfg_index, cfg_data
// Load: the next request may follow at once.
// Evaluate: fetch, copy k points, then k(k-1)/2 blends on work memory, each read, multiplied
// and written back by one blend unit per coordinate; then read back and present.
// Errors answer in the cycle after acceptance. Reset clears the sequencer and the output
// valid, sets order 1 and count 2; the control point memory keeps its contents.
// A result waits in the output register and stalls the input until it is taken.
module uniform_bspline_point_eval import ubsp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_D,
  parameter int MAX_ORDER = MAX_ORDER_D,
  parameter int U_FRAC_BITS = U_FRAC_BITS_D
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_cmd,
  input  wire logic [5:0]                in_point_index,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,
  input  wire logic signed [COORD_W-1:0] in_coord_z,
  input  wire logic [U_W-1:0]            in_param_u,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_W-1:0]      out_point_x,
  output logic signed [COORD_W-1:0]      out_point_y,
  output logic signed [COORD_W-1:0]      out_point_z,
  output logic [1:0]                     out_status,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);
  localparam int PA = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int WA = $clog2(MAX_ORDER);
  localparam int KW = $clog2(MAX_ORDER + 1);
  localparam int IW = U_W - U_FRAC_BITS + 1;
  localparam int VW = 3 * COORD_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FETCH = 8'b00000010,
    S_COPY  = 8'b00000100,
    S_RD    = 8'b00001000,
    S_MUL   = 8'b00010000,
    S_WB    = 8'b00100000,
    S_LAST  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [ORDER_W-1:0] order_r;
  logic [COUNT_W-1:0] count_r;
  logic [U_W-1:0] u_r;
  logic [IW-1:0] base_r;
  logic [KW-1:0] k_r, i_r, r_r;
  logic [U_FRAC_BITS:0] alpha_r;

  logic [VW-1:0] pts [MAX_POINTS];
  logic [VW-1:0] work [MAX_ORDER];
  logic [VW-1:0] pt_q_r, wl_q_r, wr_q_r;
  logic [WA-1:0] copy_wa_r;

  logic out_valid_r;
  logic [VW-1:0] out_data_r;
  logic [1:0] out_status_r;

  logic accept, out_free, bad_cfg, bad_u;
  logic [IW-1:0] up, top;
  logic [VW-1:0] bres;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept = in_valid && !in_stall;

  assign bad_cfg = (order_r == '0) || (32'(order_r) > MAX_ORDER) || (count_r < 7'd2) ||
                   (32'(count_r) > MAX_POINTS) || (7'(order_r) > count_r);
  assign bad_u = (in_param_u < U_W'({order_r - 4'd1, {U_FRAC_BITS{1'b0}}})) ||
                 (in_param_u > U_W'({count_r, {U_FRAC_BITS{1'b0}}}));
  assign up = IW'((24'(in_param_u) + 24'((1 << U_FRAC_BITS) - 1)) >> U_FRAC_BITS);
  assign top = (up > IW'(order_r)) ? up : IW'(order_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 4'd1;
      count_r <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORDER: order_r <= cfg_data[ORDER_W-1:0];
        CFG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control point memory: load writes, sequencer reads
  logic [PA-1:0] prd_a;
  assign prd_a = PA'(base_r + IW'(i_r));
  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_LOAD && 32'(in_point_index) < MAX_POINTS)
      pts[PA'(in_point_index)] <= {in_coord_z, in_coord_y, in_coord_x};
    pt_q_r <= pts[prd_a];
  end

  // blend weight for point i at level r
  logic [IW+U_FRAC_BITS-1:0] lo;
  logic [IW+U_FRAC_BITS-1:0] w, dmax;
  logic [KW-1:0] d;
  logic [IW+U_FRAC_BITS+RECIP_BITS+1:0] prod;
  logic [U_FRAC_BITS:0] alpha_c;
  always_comb begin
    d = k_r - r_r;
    lo = (IW+U_FRAC_BITS)'(base_r + IW'(i_r) + IW'(r_r)) << U_FRAC_BITS;
    dmax = (IW+U_FRAC_BITS)'(d) << U_FRAC_BITS;
    w = ((IW+U_FRAC_BITS)'(u_r) > lo) ? (IW+U_FRAC_BITS)'(u_r) - lo : '0;
    if (w > dmax) w = dmax;
    prod = ($bits(prod))'(w) * ($bits(prod))'(recip_rom((ORDER_W+1)'(d))) +
           ($bits(prod))'(1 << (RECIP_BITS - 1));
    prod = prod >> RECIP_BITS;
    alpha_c = (prod > ($bits(prod))'(1 << U_FRAC_BITS)) ?
              (U_FRAC_BITS+1)'(1 << U_FRAC_BITS) : (U_FRAC_BITS+1)'(prod);
  end

  // work memory: copy writes, read neighbors, write blended entry
  logic [WA-1:0] wi;
  assign wi = WA'(i_r);
  always_ff @(posedge clk) begin
    if (state_r == S_COPY) work[copy_wa_r] <= pt_q_r;
    else if (state_r == S_WB) work[wi] <= bres;
    wl_q_r <= work[wi];
    wr_q_r <= work[WA'(i_r + KW'(1))];
  end

  for (genvar c = 0; c < 3; c++) begin : g_bl
    ubsp_blend #(.U_FRAC_BITS(U_FRAC_BITS)) u_bl (
      .clk(clk),
      .left(wl_q_r[c*COORD_W +: COORD_W]),
      .right(wr_q_r[c*COORD_W +: COORD_W]),
      .alpha(alpha_r),
      .res(bres[c*COORD_W +: COORD_W])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_cmd == CMD_EVAL && !bad_cfg && !bad_u) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_COPY;
      S_COPY: state_nxt = (32'(copy_wa_r) + 1 == int'(k_r)) ?
                          ((k_r == KW'(1)) ? S_LAST : S_RD) : S_COPY;
      S_RD: state_nxt = S_MUL;
      S_MUL: state_nxt = S_WB;
      S_WB: state_nxt = (i_r + r_r + KW'(1) < k_r) ? S_RD :
                        ((r_r + KW'(1) < k_r) ? S_RD : S_LAST);
      S_LAST: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (accept && in_cmd == CMD_EVAL && (bad_cfg || bad_u)) out_valid_r <= 1'b1;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        u_r <= in_param_u;
        base_r <= top - IW'(order_r);
        k_r <= KW'(order_r);
        i_r <= '0;
        r_r <= KW'(1);
        copy_wa_r <= '0;
        if (accept && in_cmd == CMD_EVAL) begin
          out_data_r <= '0;
          out_status_r <= bad_cfg ? ST_BADCFG : ST_URANGE;
        end
      end
      S_FETCH: i_r <= i_r + KW'(1);
      S_COPY: begin
        copy_wa_r <= copy_wa_r + WA'(1);
        i_r <= (32'(copy_wa_r) + 1 == int'(k_r)) ? '0 : i_r + KW'(1);
      end
      S_RD: alpha_r <= alpha_c;
      S_MUL: ;
      S_WB: begin
        if (i_r + r_r + KW'(1) < k_r) i_r <= i_r + KW'(1);
        else begin
          i_r <= '0;
          r_r <= r_r + KW'(1);
        end
      end
      // read back the final entry 0
      S_LAST: ;
      S_DONE: if (out_free) begin
        out_data_r <= wl_q_r;
        out_status_r <= ST_OK;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_point_x = out_data_r[0 +: COORD_W];
  assign out_point_y = out_data_r[COORD_W +: COORD_W];
  assign out_point_z = out_data_r[2*COORD_W +: COORD_W];
  assign out_status = out_status_r;
endmodule
`default_nettype wire

FILE: rtl/core/ubsp_blend.sv
`default_nettype none
// Two-stage coordinate blend: multiply, then round and shift.
module ubsp_blend import ubsp_pkg::*; #(
  parameter int U_FRAC_BITS = U_FRAC_BITS_D
) (
  input  wire logic                      clk,
  input  wire logic signed [COORD_W-1:0] left,
  input  wire logic signed [COORD_W-1:0] right,
  input  wire logic [U_FRAC_BITS:0]      alpha,
  output logic signed [COORD_W-1:0]      res
);
  localparam int PW = COORD_W + U_FRAC_BITS + 2;
  logic signed [PW-1:0] pl_r, pr_r;
  logic signed [PW:0] s;
  logic [U_FRAC_BITS:0] one;

  assign one = (U_FRAC_BITS+1)'(1) << U_FRAC_BITS;

  // register each product
  always_ff @(posedge clk) begin
    pl_r <= PW'(left) * PW'(signed'({1'b0, one - alpha}));
    pr_r <= PW'(right) * PW'(signed'({1'b0, alpha}));
  end

  // round and floor-shift
  always_comb begin
    s = (PW+1)'(pl_r) + (PW+1)'(pr_r) + (PW+1)'(signed'({1'b0, one >> 1}));
    res = COORD_W'(s >>> U_FRAC_BITS);
  end
endmodule
`default_nettype wire
